/* sv/psou_pkg.sv */
// Shared types and codes for the particle update core.
// Used by the controller, the datapath, the register block and the top level.
package psou_pkg;

  // action codes carried in tuser
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_UPDATE  = 2'd1;
  localparam logic [1:0] ACT_FITNESS = 2'd2;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_INERTIA   = 2'd0;
  localparam logic [1:0] REG_COGNITIVE = 2'd1;
  localparam logic [1:0] REG_SOCIAL    = 2'd2;

  // register reset values, signed Q4.12
  localparam logic signed [15:0] INERTIA_RST   = 16'sd2986;
  localparam logic signed [15:0] COGNITIVE_RST = 16'sd6103;
  localparam logic signed [15:0] SOCIAL_RST    = 16'sd6103;

  localparam logic signed [31:0] FIT_MAX = 32'sh7FFF_FFFF;

  // stream widths
  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;

  // decoded operation of the captured item
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_UPDATE,
    OP_FITNESS,
    OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_COPY,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [15:0] inertia;
    logic signed [15:0] cognitive;
    logic signed [15:0] social;
  } weights_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic fit_eval;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic copy_rd;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic better;
    logic copy_last;
    logic out_free;
  } status_t;

endpackage

/* sv/psou_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psou_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/psou_cfg.sv */
// APB-style register block holding the three Q4.12 weights.
// Depends on psou_pkg for register codes and reset values.
module psou_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output psou_pkg::weights_t  weights
);

  psou_pkg::weights_t w_r;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign weights    = w_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.inertia   <= psou_pkg::INERTIA_RST;
      w_r.cognitive <= psou_pkg::COGNITIVE_RST;
      w_r.social    <= psou_pkg::SOCIAL_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        psou_pkg::REG_INERTIA:   w_r.inertia   <= cfg_pwdata[15:0];
        psou_pkg::REG_COGNITIVE: w_r.cognitive <= cfg_pwdata[15:0];
        psou_pkg::REG_SOCIAL:    w_r.social    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // readback, sign extended
  always_comb begin
    case (cfg_paddr[3:2])
      psou_pkg::REG_INERTIA:   cfg_prdata = 32'(w_r.inertia);
      psou_pkg::REG_COGNITIVE: cfg_prdata = 32'(w_r.cognitive);
      psou_pkg::REG_SOCIAL:    cfg_prdata = 32'(w_r.social);
      default:                 cfg_prdata = 32'd0;
    endcase
  end

endmodule

/* sv/psou_ctrl.sv */
// Controller: sequences one item at a time through decode, the multiply
// stages, the personal-best copy sweep and the result hand-off. Uses psou_pkg.
module psou_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psou_pkg::status_t   st,
  output psou_pkg::cmd_t      cmd
);

  psou_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psou_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psou_pkg::S_IDLE: begin
        if (in_valid) state_nxt = psou_pkg::S_DECODE;
      end
      psou_pkg::S_DECODE: begin
        case (st.op)
          psou_pkg::OP_UPDATE:  state_nxt = psou_pkg::S_MUL1;
          psou_pkg::OP_FITNESS: state_nxt = st.better ? psou_pkg::S_COPY : psou_pkg::S_FINISH;
          default:              state_nxt = psou_pkg::S_FINISH;
        endcase
      end
      psou_pkg::S_MUL1: state_nxt = psou_pkg::S_MUL2;
      psou_pkg::S_MUL2: state_nxt = psou_pkg::S_MUL3;
      psou_pkg::S_MUL3: state_nxt = psou_pkg::S_SUM;
      psou_pkg::S_SUM:  state_nxt = psou_pkg::S_FINISH;
      psou_pkg::S_COPY: begin
        if (st.copy_last) state_nxt = psou_pkg::S_DRAIN;
      end
      psou_pkg::S_DRAIN: state_nxt = psou_pkg::S_FINISH;
      psou_pkg::S_FINISH: begin
        if (st.out_free) state_nxt = psou_pkg::S_IDLE;
      end
      default: state_nxt = psou_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      psou_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      psou_pkg::S_DECODE: cmd.fit_eval = (st.op == psou_pkg::OP_FITNESS);
      psou_pkg::S_MUL1:   cmd.mul1 = 1'b1;
      psou_pkg::S_MUL2:   cmd.mul2 = 1'b1;
      psou_pkg::S_MUL3:   cmd.mul3 = 1'b1;
      psou_pkg::S_SUM:    cmd.sum = 1'b1;
      psou_pkg::S_COPY:   cmd.copy_rd = 1'b1;
      psou_pkg::S_FINISH: cmd.finish = st.out_free;
      default: ;
    endcase
  end

endmodule

/* sv/psou_dp.sv */
// Datapath: item registers, the three state memories, the velocity and
// position arithmetic, best-fitness tracking and the output register.
// Depends on psou_pkg and psou_ram.
module psou_dp #(
  parameter int DIMENSIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psou_pkg::cmd_t                  cmd,
  output psou_pkg::status_t               st,
  input  psou_pkg::weights_t              weights,
  input  logic [psou_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic [psou_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psou_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DIMENSIONS - 1);
  localparam logic [8:0]    DIM_LIM  = 9'(DIMENSIONS);
  localparam logic signed [39:0] V_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] V_MIN = 40'shFF_8000_0000;

  // captured item
  logic [1:0]         act_r;
  logic [3:0]         dim_r;
  logic signed [31:0] start_r;
  logic signed [31:0] gbest_r;
  logic [15:0]        r1_r;
  logic [15:0]        r2_r;
  logic signed [31:0] fit_r;

  // arithmetic pipeline
  logic signed [31:0] x_r;
  logic signed [35:0] ti_r;
  logic signed [32:0] dp_r, dg_r;
  logic signed [33:0] tp_r, tg_r;
  logic signed [37:0] tc_r, ts_r;
  logic signed [31:0] vel_r;
  logic               clip_r;

  logic signed [31:0] best_r;
  logic               improved_r;

  logic [AW-1:0]      cnt_r;
  logic               copy_we_r;
  logic [AW-1:0]      copy_addr_r;

  logic               out_valid_r;
  logic [psou_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic [AW-1:0]      dim_addr;
  logic [AW-1:0]      pos_raddr;
  logic [31:0]        pos_rd, vel_rd, pb_rd;
  logic               st_we, pb_we;
  logic [31:0]        pos_wd, vel_wd, pb_wd;
  logic [AW-1:0]      pb_waddr;

  logic               in_range;
  psou_pkg::op_t      op;

  logic signed [47:0] prod_i;
  logic signed [49:0] prod_p, prod_g, prod_c, prod_s;
  logic signed [39:0] vsum;
  logic signed [32:0] psum;
  logic signed [31:0] pos_new;
  logic               pos_clip;

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_tuser[1:0];
      dim_r   <= in_tdata[3:0];
      start_r <= in_tdata[35:4];
      gbest_r <= in_tdata[67:36];
      r1_r    <= in_tdata[83:68];
      r2_r    <= in_tdata[99:84];
      fit_r   <= in_tdata[131:100];
    end
  end

  // decode
  assign in_range = ({5'd0, dim_r} < DIM_LIM);
  assign dim_addr = AW'(dim_r);

  always_comb begin
    case (act_r)
      psou_pkg::ACT_LOAD:    op = in_range ? psou_pkg::OP_LOAD : psou_pkg::OP_NONE;
      psou_pkg::ACT_UPDATE:  op = in_range ? psou_pkg::OP_UPDATE : psou_pkg::OP_NONE;
      psou_pkg::ACT_FITNESS: op = psou_pkg::OP_FITNESS;
      default:               op = psou_pkg::OP_NONE;
    endcase
  end

  // state memories
  assign pos_raddr = cmd.copy_rd ? cnt_r : dim_addr;
  assign st_we     = cmd.finish && (op == psou_pkg::OP_LOAD || op == psou_pkg::OP_UPDATE);
  assign pos_wd    = (op == psou_pkg::OP_LOAD) ? start_r : pos_new;
  assign vel_wd    = (op == psou_pkg::OP_LOAD) ? 32'd0 : vel_r;
  assign pb_we     = copy_we_r || (cmd.finish && op == psou_pkg::OP_LOAD);
  assign pb_waddr  = copy_we_r ? copy_addr_r : dim_addr;
  assign pb_wd     = copy_we_r ? pos_rd : start_r;

  psou_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_pos_ram (
    .clk(clk), .we(st_we), .waddr(dim_addr), .wdata(pos_wd),
    .raddr(pos_raddr), .rdata(pos_rd)
  );

  psou_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_vel_ram (
    .clk(clk), .we(st_we), .waddr(dim_addr), .wdata(vel_wd),
    .raddr(dim_addr), .rdata(vel_rd)
  );

  psou_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_pb_ram (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wd),
    .raddr(dim_addr), .rdata(pb_rd)
  );

  // stage 1: inertia product and distances to the two targets
  assign prod_i = 48'(weights.inertia) * 48'($signed(vel_rd));

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      x_r  <= pos_rd;
      ti_r <= prod_i[47:12];
      dp_r <= 33'($signed(pb_rd)) - 33'($signed(pos_rd));
      dg_r <= 33'(gbest_r) - 33'($signed(pos_rd));
    end
  end

  // stage 2: scale the distances by the random fractions
  assign prod_p = 50'(dp_r) * 50'($signed({1'b0, r1_r}));
  assign prod_g = 50'(dg_r) * 50'($signed({1'b0, r2_r}));

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      tp_r <= prod_p[49:16];
      tg_r <= prod_g[49:16];
    end
  end

  // stage 3: apply the cognitive and social weights
  assign prod_c = 50'(tp_r) * 50'(weights.cognitive);
  assign prod_s = 50'(tg_r) * 50'(weights.social);

  always_ff @(posedge clk) begin
    if (cmd.mul3) begin
      tc_r <= prod_c[49:12];
      ts_r <= prod_s[49:12];
    end
  end

  // stage 4: sum and clip the velocity
  assign vsum = 40'(ti_r) + 40'(tc_r) + 40'(ts_r);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      if (vsum > V_MAX) begin
        vel_r  <= 32'sh7FFF_FFFF;
        clip_r <= 1'b1;
      end else if (vsum < V_MIN) begin
        vel_r  <= 32'sh8000_0000;
        clip_r <= 1'b1;
      end else begin
        vel_r  <= vsum[31:0];
        clip_r <= 1'b0;
      end
    end
  end

  // new position, clipped on overflow
  assign psum     = 33'(x_r) + 33'(vel_r);
  assign pos_clip = (psum[32] != psum[31]);
  assign pos_new  = pos_clip ? (psum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : psum[31:0];

  // best fitness tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= psou_pkg::FIT_MAX;
      improved_r <= 1'b0;
    end else if (cmd.capture) begin
      improved_r <= 1'b0;
    end else if (cmd.fit_eval && st.better) begin
      best_r     <= fit_r;
      improved_r <= 1'b1;
    end
  end

  // copy sweep: read position at cnt, write personal best in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      copy_we_r <= 1'b0;
    end else begin
      copy_we_r <= cmd.copy_rd;
      if (cmd.fit_eval) begin
        cnt_r <= '0;
      end else if (cmd.copy_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr_r <= cnt_r;
  end

  // result fields
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[96:65] = best_r;
    case (op)
      psou_pkg::OP_LOAD: begin
        out_data_nxt[31:0] = start_r;
      end
      psou_pkg::OP_UPDATE: begin
        out_data_nxt[31:0]  = pos_new;
        out_data_nxt[63:32] = vel_r;
        out_data_nxt[97]    = clip_r || pos_clip;
      end
      psou_pkg::OP_FITNESS: begin
        out_data_nxt[64] = improved_r;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status
  assign st.op        = op;
  assign st.better    = (fit_r < best_r);
  assign st.copy_last = (cnt_r == LAST_IDX);
  assign st.out_free  = !out_valid_r || out_tready;

endmodule

/* sv/pso_particle_update_core.sv */
// Top level of the particle update core: input and result streams, APB port.
// Depends on psou_pkg, psou_cfg, psou_ctrl, psou_dp and psou_ram.
//
// One particle with DIMENSIONS coordinates held in three small RAMs
// (position, velocity, personal best). Each input item carries an action in
// in_tuser: load a start coordinate, update one dimension, or report a
// fitness. Every item yields exactly one result item on the out_ channel.
// Items are processed one at a time; in_tready is high only while idle.
// Steps per item, from one accept to the next with a free receiver:
//   load or out-of-range item: decode, then result hand-off
//   dimension update: decode, three registered multiply stages, one sum
//   stage, then position clip and write-back
//   fitness report: decode and hand-off, with a one-entry-per-cycle copy
//   of position into personal best and a drain step between when improved.
// The result item goes valid in the same cycle as the input reopens.
// A finished result sits in the output register; a new item is accepted
// while it waits, and that item holds in its last step until the register
// frees. Reset clears the controller, the output valid, the best fitness
// (to the most positive value) and the weights to their defaults; RAM
// contents are undefined until each dimension is loaded.
module pso_particle_update_core #(
  parameter int DIMENSIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] dim_index, [35:4] start_position, [67:36] global_best_coord,
  // [83:68] rand_personal, [99:84] rand_swarm, [131:100] fitness_value
  input  logic [psou_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [psou_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] new_position, [63:32] new_velocity, [64] improved,
  // [96:65] best_fitness_out, [97] saturated
  output logic [psou_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [3:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  psou_pkg::cmd_t     cmd;
  psou_pkg::status_t  st;
  psou_pkg::weights_t weights;

  psou_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready),
    .weights(weights)
  );

  psou_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .st(st), .cmd(cmd)
  );

  psou_dp #(.DIMENSIONS(DIMENSIONS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .st(st), .weights(weights),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // one item in flight: an accept closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in flight");

  // the copy sweep never overlaps an accept
  a_no_copy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cmd.copy_rd)
    else $error("copy sweep active while accepting an item");

  // a result is loaded only into a free output register
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  // the sweep stops after the last entry and does not reopen the input
  a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.copy_rd && st.copy_last) |=> (!cmd.copy_rd && !in_tready))
    else $error("copy sweep ran past the last entry");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the particle update core (pso_particle_update_core).
// Depends on psou_pkg and the core RTL; runs a directed table, then random
// items under several weight settings, checked against a built-in predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int DIMS = 16;
  localparam logic [1:0] ACT_NONE = 2'd3;  // action code with no effect
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 2 * DIMS + 10;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 105;
  localparam int RAND_PHASE = 4;
  localparam int HOLD_START = 2500;
  localparam int HOLD_LEN = 300;
  localparam int CALM_START = 1200;
  localparam int CALM_END = 1900;
  localparam longint POS_LIMIT = 2147483647;
  localparam longint NEG_LIMIT = -POS_LIMIT - 1;

  typedef struct {
    logic [1:0]  action;
    logic [3:0]  dim;
    logic [31:0] start_pos;
    logic [31:0] gbest;
    logic [15:0] r_personal;
    logic [15:0] r_swarm;
    logic [31:0] fitness;
  } particle_item_t;

  typedef struct {
    logic [31:0] position;
    logic [31:0] velocity;
    logic        improved;
    logic [31:0] best;
    logic        saturated;
  } particle_result_t;

  typedef struct {
    particle_item_t   item;
    bit               typed;
    particle_result_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [psou_pkg::IN_DATA_W-1:0] in_tdata;
  logic [psou_pkg::IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [psou_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // predictor state
  logic signed [31:0] pos_mem [DIMS];
  logic signed [31:0] vel_mem [DIMS];
  logic signed [31:0] pbest_mem [DIMS];
  logic signed [31:0] cur_fit;
  logic signed [31:0] best_fit;
  logic signed [15:0] w_inertia;
  logic signed [15:0] w_cognitive;
  logic signed [15:0] w_social;
  logic [DIMS-1:0]    loaded_dims;

  particle_result_t pending_results [$];
  directed_row_t    directed_rows [$];
  int weight_set [PHASES][3];

  int fail_count;
  int items_sent;
  int results_seen;
  int improved_seen;
  int clipped_seen;
  int cycle_count;
  int stall_count;

  pso_particle_update_core #(.DIMENSIONS(DIMS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor((target - x) * r / 2^16) * w / 2^12, floored
  function automatic longint pull_term(input logic signed [31:0] target,
                                       input logic signed [31:0] x,
                                       input logic [15:0] r,
                                       input logic signed [15:0] w);
    longint diff;
    longint t;
    diff = longint'(target) - longint'(x);
    t = (diff * longint'(r)) >>> 16;
    return (t * longint'(w)) >>> 12;
  endfunction

  function automatic logic signed [31:0] clip32(input longint a, inout bit hit);
    if (a > POS_LIMIT) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (a < NEG_LIMIT) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return a[31:0];
  endfunction

  // Apply one item to the particle copy and return the result it yields
  function automatic particle_result_t advance_particle(input particle_item_t it);
    particle_result_t res;
    longint acc;
    logic signed [31:0] vel;
    bit hit;
    res.position = '0;
    res.velocity = '0;
    res.improved = 1'b0;
    res.saturated = 1'b0;
    hit = 1'b0;
    case (it.action)
      psou_pkg::ACT_LOAD: begin
        pos_mem[it.dim] = it.start_pos;
        pbest_mem[it.dim] = it.start_pos;
        vel_mem[it.dim] = '0;
        loaded_dims[it.dim] = 1'b1;
        res.position = it.start_pos;
      end
      psou_pkg::ACT_UPDATE: begin
        acc = (longint'(w_inertia) * longint'(vel_mem[it.dim])) >>> 12;
        acc += pull_term(pbest_mem[it.dim], pos_mem[it.dim], it.r_personal, w_cognitive);
        acc += pull_term($signed(it.gbest), pos_mem[it.dim], it.r_swarm, w_social);
        vel = clip32(acc, hit);
        pos_mem[it.dim] = clip32(longint'(pos_mem[it.dim]) + longint'(vel), hit);
        vel_mem[it.dim] = vel;
        res.position = pos_mem[it.dim];
        res.velocity = vel;
        res.saturated = hit;
      end
      psou_pkg::ACT_FITNESS: begin
        cur_fit = it.fitness;
        if ($signed(it.fitness) < best_fit) begin
          best_fit = it.fitness;
          pbest_mem = pos_mem;
          res.improved = 1'b1;
        end
      end
      default: ;
    endcase
    res.best = best_fit;
    return res;
  endfunction

  // Pick a random item; updates of loaded dimensions are the most common kind
  function automatic particle_item_t random_item();
    particle_item_t it;
    int roll;
    int d;
    longint near;
    it.action = psou_pkg::ACT_UPDATE;
    it.dim = 4'($urandom_range(15));
    it.start_pos = $urandom;
    it.gbest = $urandom;
    it.r_personal = 16'($urandom_range(65535));
    it.r_swarm = 16'($urandom_range(65535));
    it.fitness = $urandom;
    roll = $urandom_range(99);
    if (roll < 20) begin
      it.action = psou_pkg::ACT_LOAD;
      if ($urandom_range(1) == 0) begin
        it.start_pos = $signed($urandom_range(2097151)) - 1048576;
      end else if ($urandom_range(9) == 0) begin
        it.start_pos = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    end else if (roll < 66) begin
      do d = $urandom_range(DIMS - 1); while (!loaded_dims[d]);
      it.dim = 4'(d);
      if ($urandom_range(1) == 0) begin
        near = longint'(pos_mem[d]) + longint'($urandom_range(2097151)) - 1048576;
        if (near > POS_LIMIT) near = POS_LIMIT;
        if (near < NEG_LIMIT) near = NEG_LIMIT;
        it.gbest = near[31:0];
      end
    end else if (roll < 92) begin
      it.action = psou_pkg::ACT_FITNESS;
      if ($urandom_range(9) < 6 && best_fit > -32'sd1000000000) begin
        it.fitness = best_fit - $signed($urandom_range(1048576, 1));
      end
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  task automatic add_row(input logic [1:0] a, input logic [3:0] d,
                         input logic [31:0] s, input logic [31:0] g,
                         input logic [15:0] r1, input logic [15:0] r2,
                         input logic [31:0] f, input bit typed,
                         input logic [31:0] p, input logic [31:0] v,
                         input logic imp, input logic [31:0] b, input logic sat);
    directed_row_t row;
    row.item = '{a, d, s, g, r1, r2, f};
    row.typed = typed;
    row.want = '{p, v, imp, b, sat};
    directed_rows.push_back(row);
  endtask

  // Offer one item after a random gap; predict once it is accepted
  task automatic drive_item(input particle_item_t it, input bit typed,
                            input particle_result_t want);
    particle_result_t res;
    while (!(cycle_count >= CALM_START && cycle_count < CALM_END)
           && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.action;
    in_tdata <= {4'b0, it.fitness, it.r_swarm, it.r_personal,
                 it.gbest, it.start_pos, it.dim};
    do @(posedge clk); while (!in_tready);
    res = advance_particle(it);
    pending_results.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Drop valid and hold until every pending result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one weight register over APB, then read it back
  task automatic write_weight(input logic [1:0] idx, input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      psou_pkg::REG_INERTIA:   w_inertia = value;
      psou_pkg::REG_COGNITIVE: w_cognitive = value;
      psou_pkg::REG_SOCIAL:    w_social = value;
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value) begin
      $error("weight register %0d: expected %h, got %h", idx, value, cfg_prdata[15:0]);
      fail_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random stalls, a calm stretch and one long hold-off
  initial begin : result_sink
    int rx_cycle;
    rx_cycle = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_tready <= 1'b0;
      end else if (rx_cycle >= CALM_START && rx_cycle < CALM_END) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    particle_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[64]) improved_seen++;
      if (out_tdata[97]) clipped_seen++;
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("new_position", want.position, out_tdata[31:0]);
        check_field("new_velocity", want.velocity, out_tdata[63:32]);
        check_field("improved", 32'(want.improved), 32'(out_tdata[64]));
        check_field("best_fitness_out", want.best, out_tdata[96:65]);
        check_field("saturated", 32'(want.saturated), 32'(out_tdata[97]));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    cycle_count++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[pso_particle_update_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    particle_item_t it;
    particle_result_t none;
    logic [15:0] w;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    improved_seen = 0;
    clipped_seen = 0;
    cycle_count = 0;
    stall_count = 0;
    none = '{'0, '0, 1'b0, '0, 1'b0};
    for (int i = 0; i < DIMS; i++) begin
      pos_mem[i] = '0;
      vel_mem[i] = '0;
      pbest_mem[i] = '0;
    end
    loaded_dims = '0;
    cur_fit = psou_pkg::FIT_MAX;
    best_fit = psou_pkg::FIT_MAX;
    w_inertia = psou_pkg::INERTIA_RST;
    w_cognitive = psou_pkg::COGNITIVE_RST;
    w_social = psou_pkg::SOCIAL_RST;
    weight_set = '{'{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{0, 0, 0},
                   '{4096, -4096, 2048}, '{0, 0, 0}, '{2986, 6103, 6103}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, reset weights
    add_row(psou_pkg::ACT_FITNESS, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1,
            0, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(ACT_NONE, 15, '1, '1, '1, '1, '1, 1, 0, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_LOAD, 0, 32'h7FFF_FFFF, '1, '1, '1, '1, 1,
            32'h7FFF_FFFF, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_LOAD, 15, 32'h8000_0000, 0, 0, 0, 0, 1,
            32'h8000_0000, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_LOAD, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_LOAD, 2, 32'h0001_0000, 0, 0, 0, 0, 1,
            32'h0001_0000, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_UPDATE, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, psou_pkg::FIT_MAX, 0);
    add_row(psou_pkg::ACT_UPDATE, 0, 0, 32'h7FFF_FFFF, '1, '1, 0, 0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_UPDATE, 15, 0, 32'h7FFF_FFFF, 0, '1, 0, 0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_UPDATE, 0, 0, 32'h8000_0000, 0, '1, 0, 0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_UPDATE, 2, 0, 32'h0002_0000, 16'h8000, 16'h8000, 0,
            0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_UPDATE, 2, 0, 32'h0002_0000, 16'h4000, 16'hC000, 0,
            0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_FITNESS, 0, 0, 0, 0, 0, 1000, 1, 0, 0, 1, 1000, 0);
    add_row(psou_pkg::ACT_UPDATE, 2, 0, 0, '1, 16'h1234, 0, 0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_FITNESS, 0, 0, 0, 0, 0, 1000, 1, 0, 0, 0, 1000, 0);
    add_row(psou_pkg::ACT_FITNESS, 0, 0, 0, 0, 0, 999, 1, 0, 0, 1, 999, 0);
    add_row(psou_pkg::ACT_LOAD, 3, 32'h1234_5678, 0, 0, 0, '1, 1,
            32'h1234_5678, 0, 0, 999, 0);
    add_row(psou_pkg::ACT_UPDATE, 3, 0, 32'hFFFF_0000, '1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_NONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 999, 0);
    add_row(psou_pkg::ACT_UPDATE, 15, 0, 32'h8000_0000, '1, '1, 0, 0, 0, 0, 0, 0, 0);
    add_row(psou_pkg::ACT_UPDATE, 15, 0, 32'h7FFF_FFFF, 0, 16'h8000, 0,
            0, 0, 0, 0, 0, 0);
    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // random phases, one weight setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 3; r++) begin
        w = (ph == RAND_PHASE) ? 16'($urandom_range(65535)) : 16'(weight_set[ph][r]);
        write_weight(2'(r), w);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it = random_item();
        drive_item(it, 1'b0, none);
      end
      drain_results();
    end

    // most negative fitness always wins
    it = '{psou_pkg::ACT_FITNESS, 0, 0, 0, 0, 0, 32'h8000_0000};
    drive_item(it, 1'b0, none);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d results) over %0d weight settings",
             items_sent, results_seen, PHASES + 1);
    $display("fitness improvements %0d, clipped updates %0d", improved_seen, clipped_seen);
    if (fail_count == 0) begin
      $display("[pso_particle_update_core] OK");
    end else begin
      $display("[pso_particle_update_core] ERROR");
    end
    $finish;
  end

endmodule
